/* rtl/shadow_memory_access_checker_macros.svh */
// assertion macros for the shadow memory access checker
// used by smac_back; expects i_clk and i_rst_n in the including module
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_MACROS_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_MACROS_SVH

// same-cycle implication, off while in reset
`define SMAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SMAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/smac_pkg.sv */
// shared types and constants of the shadow memory access checker
// no dependencies; used by every module of the block
package smac_pkg;

    localparam int ADDR_BITS       = 16;
    localparam int GRANULE_SHIFT   = 3;
    localparam int GRANULE_BYTES   = 1 << GRANULE_SHIFT;
    localparam int REDZONE_BYTES   = 16;
    localparam int MAX_ALLOC_BYTES = 4096;

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 13;
    localparam int CODE_W  = 4;

    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    localparam logic [CODE_W-1:0] CODE_OK     = 4'd0;
    localparam logic [CODE_W-1:0] CODE_POISON = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic              error;
        logic [ADDR_W-1:0] user_address;
    } t_job;

endpackage

/* rtl/shadow_memory_access_checker.sv */
// shadow memory access checker, top level
// depends on smac_pkg, smac_front, smac_queue, smac_back
//
// usage:
//   request channel i_valid/o_ready carries i_cmd, i_address, i_size
//   (check, allocate, release); result channel o_valid/i_ready carries
//   o_error and o_user_address, exactly one result per request, in order.
//   the front end screens allocations and drops requests into a two-entry
//   queue; the back end owns the shadow store (one 4-bit code per granule,
//   one write and one read port) and walks it one granule per cycle.
//   a check reads one shadow code; an allocation writes the left redzone,
//   body and right redzone granules; a release poisons the zero granules
//   it walks and the first nonzero one; refused or unused requests need no walk.
//   one request is in work at a time, so throughput follows the write
//   walk of the store port; the queue keeps taking requests meanwhile.
//   after reset the store is swept to poisoned, all 2^(ADDR_BITS-3) granules
//   (8192 by default), with o_ready low. a stalled receiver holds the
//   result register; the back end waits, then the queue fills, then
//   o_ready drops.
module shadow_memory_access_checker #(
    parameter int ADDR_BITS       = smac_pkg::ADDR_BITS,
    parameter int REDZONE_BYTES   = smac_pkg::REDZONE_BYTES,
    parameter int MAX_ALLOC_BYTES = smac_pkg::MAX_ALLOC_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [smac_pkg::CMD_W-1:0]  i_cmd,
    input  logic [smac_pkg::ADDR_W-1:0] i_address,
    input  logic [smac_pkg::SIZE_W-1:0] i_size,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_error,
    output logic [smac_pkg::ADDR_W-1:0] o_user_address
);

    smac_pkg::t_job push_job;
    smac_pkg::t_job head_job;
    logic           push;
    logic           full;
    logic           head_valid;
    logic           pop;
    logic           clearing;

    smac_front #(
        .ADDR_BITS       (ADDR_BITS),
        .REDZONE_BYTES   (REDZONE_BYTES),
        .MAX_ALLOC_BYTES (MAX_ALLOC_BYTES)
    ) u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_address  (i_address),
        .i_size     (i_size),
        .i_full     (full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_job      (push_job)
    );

    smac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    smac_back #(
        .ADDR_BITS     (ADDR_BITS),
        .REDZONE_BYTES (REDZONE_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (head_valid),
        .i_job          (head_job),
        .o_job_pop      (pop),
        .o_clearing     (clearing),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_error        (o_error),
        .o_user_address (o_user_address)
    );

endmodule

/* rtl/smac_front.sv */
// front end: accepts requests, decodes the command and screens allocations
// depends on smac_pkg
module smac_front #(
    parameter int ADDR_BITS       = smac_pkg::ADDR_BITS,
    parameter int REDZONE_BYTES   = smac_pkg::REDZONE_BYTES,
    parameter int MAX_ALLOC_BYTES = smac_pkg::MAX_ALLOC_BYTES
) (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [smac_pkg::CMD_W-1:0]      i_cmd,
    input  logic [smac_pkg::ADDR_W-1:0]     i_address,
    input  logic [smac_pkg::SIZE_W-1:0]     i_size,
    input  logic                            i_full,
    input  logic                            i_clearing,
    output logic                            o_push,
    output smac_pkg::t_job                  o_job
);

    localparam int EW = ((ADDR_BITS > 14) ? ADDR_BITS : 14) + 2;
    localparam logic [EW-1:0] SPAN = EW'(1) << ADDR_BITS;
    localparam logic [EW-1:0] RZ   = EW'(REDZONE_BYTES);

    logic [ADDR_BITS-1:0] base;
    logic [EW-1:0]        base_ext;
    logic [EW-1:0]        size_ext;
    logic                 refuse;

    assign base     = ADDR_BITS'(i_address);
    assign base_ext = EW'(base);
    assign size_ext = EW'(i_size);
    assign refuse   = (32'(i_size) > 32'(MAX_ALLOC_BYTES))
                   || ((base_ext + size_ext + RZ + RZ) > SPAN);

    assign o_ready = !i_full && !i_clearing;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_job.cmd          = i_cmd;
        o_job.address      = i_address;
        o_job.size         = i_size;
        o_job.error        = 1'b0;
        o_job.user_address = '0;
        if (i_cmd == smac_pkg::CMD_ALLOC) begin
            if (refuse) begin
                o_job.cmd   = smac_pkg::CMD_NOP;
                o_job.error = 1'b1;
            end else begin
                o_job.user_address = smac_pkg::ADDR_W'(base_ext + RZ);
            end
        end
    end

endmodule

/* rtl/smac_queue.sv */
// two-entry request queue between front end and back end
// depends on smac_pkg
module smac_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smac_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output smac_pkg::t_job o_job,
    input  logic           i_pop
);

    smac_pkg::t_job r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp;
    logic           n_rp;
    logic [1:0]     n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

/* rtl/smac_back.sv */
// back end: shadow store, check/allocate/release sequencer, result register
// depends on smac_pkg and shadow_memory_access_checker_macros.svh
`include "shadow_memory_access_checker_macros.svh"

module smac_back #(
    parameter int ADDR_BITS     = smac_pkg::ADDR_BITS,
    parameter int REDZONE_BYTES = smac_pkg::REDZONE_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  smac_pkg::t_job              i_job,
    output logic                        o_job_pop,
    output logic                        o_clearing,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_error,
    output logic [smac_pkg::ADDR_W-1:0] o_user_address
);

    localparam int GS = smac_pkg::GRANULE_SHIFT;
    localparam int GW = ADDR_BITS - GS;
    localparam int EW = ((ADDR_BITS > 14) ? ADDR_BITS : 14) + 2;
    localparam int unsigned DEPTH = 2 ** GW;
    localparam logic [EW-1:0] SPAN = EW'(1) << ADDR_BITS;
    localparam logic [EW-1:0] STEP = EW'(smac_pkg::GRANULE_BYTES);
    localparam logic [EW-1:0] RZ   = EW'(REDZONE_BYTES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_LEFT  = 3'd3;
    localparam logic [2:0] ST_BODY  = 3'd4;
    localparam logic [2:0] ST_RIGHT = 3'd5;
    localparam logic [2:0] ST_REL   = 3'd6;

    logic [smac_pkg::CODE_W-1:0] r_shadow [DEPTH];
    logic [smac_pkg::CODE_W-1:0] r_rdata;

    logic [2:0]                  r_state, n_state;
    logic [EW-1:0]               r_p, n_p;
    logic [EW-1:0]               r_u, n_u;
    logic [EW-1:0]               r_end, n_end;
    logic [EW-1:0]               r_endr, n_endr;
    logic [GW-1:0]               r_g, n_g;
    logic [GW:0]                 r_cnt, n_cnt;
    logic [GS-1:0]               r_off, n_off;
    logic [smac_pkg::SIZE_W-1:0] r_size, n_size;
    logic [smac_pkg::ADDR_W-1:0] r_juser, n_juser;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_error, n_out_error;
    logic [smac_pkg::ADDR_W-1:0] r_out_user, n_out_user;

    logic                        mem_we;
    logic [GW-1:0]               mem_waddr;
    logic [smac_pkg::CODE_W-1:0] mem_wdata;
    logic [GW-1:0]               mem_raddr;

    logic                        slot_free;
    logic [ADDR_BITS-1:0]        job_a;
    logic [EW-1:0]               job_b;
    logic [EW-1:0]               job_size;
    logic [EW-1:0]               rest;
    logic [GW:0]                 steps;
    logic [smac_pkg::SIZE_W:0]   reach;

    assign slot_free  = !r_out_valid || i_ready;
    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid && slot_free;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid        = r_out_valid;
    assign o_error        = r_out_error;
    assign o_user_address = r_out_user;

    assign job_a    = ADDR_BITS'(i_job.address);
    assign job_b    = EW'(job_a);
    assign job_size = EW'(i_job.size);
    assign rest     = r_end - r_p;
    assign steps    = r_cnt + (GW+1)'(1);
    assign reach    = (smac_pkg::SIZE_W+1)'(r_off) + (smac_pkg::SIZE_W+1)'(r_size);

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_u         = r_u;
        n_end       = r_end;
        n_endr      = r_endr;
        n_g         = r_g;
        n_cnt       = r_cnt;
        n_off       = r_off;
        n_size      = r_size;
        n_juser     = r_juser;
        n_out_valid = r_out_valid && !i_ready;
        n_out_error = r_out_error;
        n_out_user  = r_out_user;
        mem_we      = 1'b0;
        mem_waddr   = r_p[ADDR_BITS-1:GS];
        mem_wdata   = smac_pkg::CODE_POISON;
        mem_raddr   = job_a[ADDR_BITS-1:GS];
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_g;
                n_g       = r_g + GW'(1);
                if (r_g == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_job_pop) begin
                    case (i_job.cmd)
                        smac_pkg::CMD_CHECK: begin
                            n_off   = job_a[GS-1:0];
                            n_size  = i_job.size;
                            n_state = ST_CHECK;
                        end
                        smac_pkg::CMD_ALLOC: begin
                            n_p     = job_b;
                            n_u     = job_b + RZ;
                            n_end   = job_b + RZ + job_size;
                            n_endr  = job_b + job_size + RZ + RZ;
                            n_juser = i_job.user_address;
                            n_state = ST_LEFT;
                        end
                        smac_pkg::CMD_RELEASE: begin
                            n_g     = job_a[ADDR_BITS-1:GS];
                            n_cnt   = '0;
                            n_juser = i_job.user_address;
                            n_state = ST_REL;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_error = i_job.error;
                            n_out_user  = i_job.user_address;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                n_out_valid = 1'b1;
                n_out_error = (r_rdata != smac_pkg::CODE_OK)
                           && (r_rdata[smac_pkg::CODE_W-1]
                               || (reach > (smac_pkg::SIZE_W+1)'(r_rdata)));
                n_out_user  = '0;
                n_state     = ST_IDLE;
            end
            ST_LEFT: begin
                if (r_p < r_u) begin
                    mem_we = 1'b1;
                    n_p    = r_p + STEP;
                end else begin
                    n_p     = r_u;
                    n_state = ST_BODY;
                end
            end
            ST_BODY: begin
                if (r_p < r_end) begin
                    mem_we    = 1'b1;
                    mem_wdata = (rest >= STEP) ? smac_pkg::CODE_OK
                                               : smac_pkg::CODE_W'(rest);
                    n_p       = r_p + STEP;
                end else begin
                    n_state = ST_RIGHT;
                end
            end
            ST_RIGHT: begin
                if (r_p < r_endr) begin
                    mem_we = 1'b1;
                    n_p    = r_p + STEP;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_error = 1'b0;
                    n_out_user  = r_juser;
                    n_state     = ST_IDLE;
                end
            end
            ST_REL: begin
                mem_we    = 1'b1;
                mem_waddr = r_g;
                mem_raddr = r_g + GW'(1);
                if ((r_rdata == smac_pkg::CODE_OK) && (steps != (GW+1)'(DEPTH))) begin
                    n_g   = r_g + GW'(1);
                    n_cnt = steps;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_error = 1'b0;
                    n_out_user  = r_juser;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_g         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_g         <= n_g;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_u         <= n_u;
        r_end       <= n_end;
        r_endr      <= n_endr;
        r_cnt       <= n_cnt;
        r_off       <= n_off;
        r_size      <= n_size;
        r_juser     <= n_juser;
        r_out_error <= n_out_error;
        r_out_user  <= n_out_user;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_shadow[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_shadow[mem_raddr];
    end

    `SMAC_ASSERT_NOW(a_busy_slot_empty,
        (r_state == ST_CHECK || r_state == ST_LEFT || r_state == ST_BODY
         || r_state == ST_RIGHT || r_state == ST_REL),
        !r_out_valid, "result register occupied while a request is in work")
    `SMAC_ASSERT_NOW(a_write_states, mem_we,
        (r_state != ST_IDLE && r_state != ST_CHECK), "shadow write outside a walk")
    `SMAC_ASSERT_NOW(a_alloc_in_range,
        mem_we && (r_state == ST_LEFT || r_state == ST_BODY || r_state == ST_RIGHT),
        r_p < SPAN, "allocation walk left the covered range")
    `SMAC_ASSERT_NEXT(a_release_bounded, r_state == ST_REL,
        (r_cnt != (GW+1)'(DEPTH)), "release walk ran past the whole store")

endmodule
